// ===== rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser, queue and output stage.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HEAD0  = 3'd0,
    PH_HEAD1  = 3'd1,
    PH_EXT16  = 3'd2,
    PH_EXT64  = 3'd3,
    PH_MASK   = 3'd4,
    PH_DATA   = 3'd5,
    PH_CLOSED = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  localparam logic [3:0] OPCODE_CLOSE = 4'd8;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [2:0] EXT16_BYTES  = 3'd2;
  localparam logic [2:0] EXT64_LAST   = 3'd7;
  localparam logic [2:0] MASK_BYTES   = 3'd4;

  localparam logic [1:0] QUEUE_DEPTH  = 2'd2;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] mask;
    logic       last;
    logic [3:0] opcode;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/wsd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer receive byte channel
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer result channel
// Valid/ready channel carrying one deframed result per transaction.
// ----------------------------------------------------------------------------
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_kind;
  logic [7:0] data_byte;
  logic       message_last;
  logic [3:0] frame_opcode;

  modport source (output valid, output frame_kind, output data_byte,
                  output message_last, output frame_opcode, input ready);
  modport sink (input valid, input frame_kind, input data_byte,
                input message_last, input frame_opcode, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses frame headers, tracks length and mask position, and pushes one
// classified entry per result into the queue.
// ----------------------------------------------------------------------------
module wsd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 in_ready_o,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output wsd_pkg::entry_t      entry_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      opcode_q, opcode_d;
  logic [63:0]     len_q, len_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [31:0]     key_q, key_d;
  logic [1:0]      idx_q, idx_d;
  logic            accept;
  logic [2:0]      cnt_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsd_pkg::PH_HEAD0;
      opcode_q <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      key_q    <= '0;
      idx_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
    end
  end

  always_comb begin
    phase_d        = phase_q;
    opcode_d       = opcode_q;
    len_d          = len_q;
    cnt_d          = cnt_q;
    key_d          = key_q;
    idx_d          = idx_q;
    push_o         = 1'b0;
    entry_o.kind   = wsd_pkg::KIND_DATA;
    entry_o.data   = '0;
    entry_o.mask   = '0;
    entry_o.last   = 1'b0;
    entry_o.opcode = opcode_q;
    if (accept) begin
      unique case (phase_q)
        wsd_pkg::PH_HEAD1: begin
          if (opcode_q == wsd_pkg::OPCODE_CLOSE) begin
            phase_d      = wsd_pkg::PH_CLOSED;
            push_o       = 1'b1;
            entry_o.kind = wsd_pkg::KIND_CLOSE;
          end else begin
            len_d = '0;
            cnt_d = '0;
            if (rx_byte_i[6:0] == wsd_pkg::LEN_EXT16) begin
              phase_d = wsd_pkg::PH_EXT16;
            end else if (rx_byte_i[6:0] == wsd_pkg::LEN_EXT64) begin
              phase_d = wsd_pkg::PH_EXT64;
            end else begin
              len_d   = {57'd0, rx_byte_i[6:0]};
              phase_d = wsd_pkg::PH_MASK;
            end
          end
        end
        wsd_pkg::PH_EXT16: begin
          len_d = {len_q[55:0], rx_byte_i};
          cnt_d = cnt_inc;
          if (cnt_inc == wsd_pkg::EXT16_BYTES) begin
            cnt_d   = '0;
            phase_d = wsd_pkg::PH_MASK;
          end
        end
        wsd_pkg::PH_EXT64: begin
          len_d = {len_q[55:0], rx_byte_i};
          if (cnt_q == wsd_pkg::EXT64_LAST) begin
            cnt_d   = '0;
            phase_d = wsd_pkg::PH_MASK;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        wsd_pkg::PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_inc;
          if (cnt_inc == wsd_pkg::MASK_BYTES) begin
            cnt_d = '0;
            idx_d = '0;
            if (len_q == 64'd0) begin
              phase_d      = wsd_pkg::PH_HEAD0;
              push_o       = 1'b1;
              entry_o.kind = wsd_pkg::KIND_EMPTY;
              entry_o.last = 1'b1;
            end else begin
              phase_d = wsd_pkg::PH_DATA;
            end
          end
        end
        wsd_pkg::PH_DATA: begin
          len_d        = len_q - 64'd1;
          idx_d        = idx_q + 2'd1;
          push_o       = 1'b1;
          entry_o.data = rx_byte_i;
          entry_o.mask = key_q[{~idx_q, 3'b000} +: 8];
          entry_o.last = (len_q == 64'd1);
          if (len_q == 64'd1) begin
            phase_d = wsd_pkg::PH_HEAD0;
          end
        end
        wsd_pkg::PH_CLOSED: begin
          phase_d = wsd_pkg::PH_CLOSED;
        end
        default: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = wsd_pkg::PH_HEAD1;
        end
      endcase
    end
  end

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsd_pkg::PH_CLOSED |=> phase_q == wsd_pkg::PH_CLOSED)
    else $error("front left the closed state");

  a_data_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != wsd_pkg::PH_DATA) ##1 (phase_q == wsd_pkg::PH_DATA) |->
    (idx_q == 2'd0 && len_q != 64'd0))
    else $error("payload started with a stale index or zero length");

endmodule
`default_nettype wire

// ===== rtl/wsd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer entry queue
// Two-entry FIFO between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wsd_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire wsd_pkg::entry_t  entry_i,
  input  wire logic             pop_i,
  output wsd_pkg::entry_t       head_o,
  output logic                  empty_o,
  output logic                  full_o
);

  wsd_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == wsd_pkg::QUEUE_DEPTH);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wsd_pkg::QUEUE_DEPTH)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

// ===== rtl/wsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer output stage
// Pops queue entries, unmasks payload bytes and holds the result register.
// ----------------------------------------------------------------------------
module wsd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire wsd_pkg::entry_t  head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            frame_kind_o,
  output logic [7:0]            data_byte_o,
  output logic                  message_last_o,
  output logic [3:0]            frame_opcode_o
);

  logic       valid_q, valid_d;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic       last_q;
  logic [3:0] opcode_q;

  assign pop_o   = !empty_i && (!valid_q || out_ready_i);
  assign valid_d = pop_o || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= head_i.kind;
      data_q   <= head_i.data ^ head_i.mask;
      last_q   <= head_i.last;
      opcode_q <= head_i.opcode;
    end
  end

  assign out_valid_o    = valid_q;
  assign frame_kind_o   = kind_q;
  assign data_byte_o    = data_q;
  assign message_last_o = last_q;
  assign frame_opcode_o = opcode_q;

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Takes the client-to-server byte stream on in_i, one byte per transaction,
// and returns unmasked payload bytes, empty-message marks and a close mark on
// out_o. Header, length and mask bytes produce no result; a close frame
// produces one close result, after which all bytes are consumed silently
// until reset.
// The header parser classifies each byte in the cycle it is accepted and
// writes any result into a two-entry queue; the output stage unmasks the
// payload byte into the output register. A result is registered first in the
// queue and then in the output register. The block sustains one byte per
// cycle while the queue is not full; when the receiver stalls, the output
// register holds its result and the queue absorbs up to two more results
// before in_i.ready drops. Reset clears the parser to expect a new frame
// header and empties the queue and the output register.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wsd_in_if.sink    in_i,
  wsd_out_if.source out_o
);

  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  wsd_pkg::entry_t push_entry;
  wsd_pkg::entry_t head_entry;

  wsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .rx_byte_i  (in_i.rx_byte),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_entry),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .frame_kind_o   (out_o.frame_kind),
    .data_byte_o    (out_o.data_byte),
    .message_last_o (out_o.message_last),
    .frame_opcode_o (out_o.frame_opcode)
  );

endmodule
`default_nettype wire
